/* src/comb_sort_engine_defines.svh */
// Assertion macros shared by the comb sort checks.
`ifndef COMB_SORT_ENGINE_DEFINES_SVH
`define COMB_SORT_ENGINE_DEFINES_SVH

// Consequent must hold in the cycle after the antecedent.
`define CSE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("comb sort check failed: next-cycle rule");

// Consequent must hold in the same cycle as the antecedent.
`define CSE_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("comb sort check failed: same-cycle rule");

`endif

/* src/cse_pkg.sv */
// Types, constants and the gap update shared by the comb sort engine.
package cse_pkg;

	// Gap shrink factor 1.3 taken as 10/13; divide by 13 via reciprocal 5042/2^16.
	localparam logic [10:0] GAP_MUL      = 11'd10;
	localparam logic [22:0] GAP_RECIP    = 23'd5042;
	localparam logic [6:0]  GAP_RAISE_LO = 7'd9;
	localparam logic [6:0]  GAP_RAISE_HI = 7'd10;
	localparam logic [6:0]  GAP_RAISED   = 7'd11;
	localparam logic [6:0]  GAP_MIN      = 7'd1;

	typedef struct packed {
		logic signed [31:0] value;
		logic               last;
	} load_req_t;

	typedef struct packed {
		logic signed [31:0] sorted_value;
		logic               last_out;
		logic               overflow;
	} result_t;

	typedef enum logic [1:0] {
		WSEL_INPUT,
		WSEL_B,
		WSEL_HOLD
	} wsel_t;

	typedef struct packed {
		logic  we;
		wsel_t wsel;
		logic  hold_en;
		logic  load_out;
		logic  out_last;
		logic  out_ovf;
	} cmd_t;

	typedef struct packed {
		logic gt;
		logic out_free;
	} status_t;

	function automatic logic [6:0] next_gap(input logic [6:0] gap);
		logic [10:0] scaled;
		logic [22:0] prod;
		logic [6:0]  n;
		scaled = 11'(gap) * GAP_MUL;
		prod   = 23'(scaled) * GAP_RECIP;
		n      = prod[22:16];
		if (n == GAP_RAISE_LO || n == GAP_RAISE_HI) begin
			n = GAP_RAISED;
		end
		if (n < GAP_MIN) begin
			n = GAP_MIN;
		end
		return n;
	endfunction

endpackage

/* src/comb_sort_engine.sv */
// Top level of the comb sort engine: controller plus datapath.
//
//  channel  direction  payload      handshake
//  load     in         load_req_t   load_valid / load_stall
//  result   out        result_t     result_valid / result_stall
//
// Loading takes one request per cycle while load_stall is low; the request marked
// last starts the sort. Sorting: each pass opens in ST_PASS; a compare runs ST_CHK,
// ST_RD, ST_CMP, plus ST_WR2 on a swap (the store has a single write port); a phase
// ends in ST_CHK. Emission: per element ST_E_RD, then ST_E_LD, which waits out result
// stalls; the final element sits in the output register while new loads are taken.
// Reset (arst_n low) empties the store count and drops any batch in progress.
// load_stall stays high from the last request until the final result is registered.
module comb_sort_engine import cse_pkg::*; #(
	parameter int DEPTH = 64
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      load_valid,
	output logic      load_stall,
	input  load_req_t load_data,
	output logic      result_valid,
	input  logic      result_stall,
	output result_t   result_data
);

	localparam int AW = $clog2(DEPTH);

	cmd_t          cmd;
	status_t       status;
	logic [AW-1:0] waddr;
	logic [AW-1:0] raddr_a;
	logic [AW-1:0] raddr_b;

	// Sequence load, passes and emission.
	cse_ctrl #(.DEPTH(DEPTH)) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.load_valid (load_valid),
		.load_last  (load_data.last),
		.load_stall (load_stall),
		.status     (status),
		.cmd        (cmd),
		.waddr      (waddr),
		.raddr_a    (raddr_a),
		.raddr_b    (raddr_b)
	);

	// Hold the elements, compare pairs and register results.
	cse_dp #(.DEPTH(DEPTH)) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.load_value   (load_data.value),
		.cmd          (cmd),
		.waddr        (waddr),
		.raddr_a      (raddr_a),
		.raddr_b      (raddr_b),
		.status       (status),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result_data  (result_data)
	);

endmodule

/* src/cse_ram.sv */
// Generic RAM: one write port, two registered read ports.
module cse_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr_a,
	input  logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic [WIDTH-1:0]         rdata_a,
	output logic [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_a <= mem[raddr_a];
		rdata_b <= mem[raddr_b];
	end

endmodule

/* src/cse_dp.sv */
// Datapath: element store, compare-and-swap hold register and result register.
module cse_dp import cse_pkg::*; #(
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic signed [31:0]       load_value,
	input  cmd_t                     cmd,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [$clog2(DEPTH)-1:0] raddr_a,
	input  logic [$clog2(DEPTH)-1:0] raddr_b,
	output status_t                  status,
	output logic                     result_valid,
	input  logic                     result_stall,
	output result_t                  result_data
);

	logic [31:0] rdata_a;
	logic [31:0] rdata_b;
	logic [31:0] wdata;
	logic [31:0] hold_q;
	result_t     out_q;
	logic        out_valid_q;

	cse_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_store (
		.clk     (clk),
		.we      (cmd.we),
		.waddr   (waddr),
		.wdata   (wdata),
		.raddr_a (raddr_a),
		.raddr_b (raddr_b),
		.rdata_a (rdata_a),
		.rdata_b (rdata_b)
	);

	always_comb begin
		case (cmd.wsel)
			WSEL_INPUT: wdata = load_value;
			WSEL_B:     wdata = rdata_b;
			WSEL_HOLD:  wdata = hold_q;
			default:    wdata = load_value;
		endcase
	end

	assign status.gt       = $signed(rdata_a) > $signed(rdata_b);
	assign status.out_free = !out_valid_q || !result_stall;

	// Keep the lower-position value while its partner is written back.
	always_ff @(posedge clk) begin
		if (cmd.hold_en) begin
			hold_q <= rdata_a;
		end
		if (cmd.load_out) begin
			out_q.sorted_value <= $signed(rdata_a);
			out_q.last_out     <= cmd.out_last;
			out_q.overflow     <= cmd.out_ovf;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (!result_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign result_valid = out_valid_q;
	assign result_data  = out_q;

endmodule

/* src/cse_ctrl.sv */
// Controller: load, comb sort passes and emission sequencing.
module cse_ctrl import cse_pkg::*; #(
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     load_valid,
	input  logic                     load_last,
	output logic                     load_stall,
	input  status_t                  status,
	output cmd_t                     cmd,
	output logic [$clog2(DEPTH)-1:0] waddr,
	output logic [$clog2(DEPTH)-1:0] raddr_a,
	output logic [$clog2(DEPTH)-1:0] raddr_b
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam int SW = $clog2(2 * DEPTH + 2);

	typedef enum logic [3:0] {
		ST_LOAD,
		ST_INIT,
		ST_PASS,
		ST_CHK,
		ST_RD,
		ST_CMP,
		ST_WR2,
		ST_E_RD,
		ST_E_LD
	} state_t;

	state_t        state_q;
	logic          stall_q;
	logic [CW-1:0] count_q;
	logic [CW-1:0] gap_q;
	logic [CW-1:0] k_q;
	logic [SW-1:0] i_q;
	logic          phase_q;
	logic          swapped_q;
	logic          dropped_q;
	logic [SW-1:0] j;
	logic          accept;
	logic          room;
	logic          emit_last;

	assign j         = i_q + SW'(gap_q);
	assign accept    = load_valid && !stall_q;
	assign room      = count_q < CW'(DEPTH);
	assign emit_last = (k_q + CW'(1)) == count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_LOAD;
			stall_q   <= 1'b0;
			count_q   <= '0;
			gap_q     <= '0;
			k_q       <= '0;
			i_q       <= '0;
			phase_q   <= 1'b0;
			swapped_q <= 1'b0;
			dropped_q <= 1'b0;
		end else begin
			case (state_q)
				ST_LOAD: begin
					if (accept) begin
						if (room) begin
							count_q <= count_q + CW'(1);
						end else begin
							dropped_q <= 1'b1;
						end
						if (load_last) begin
							stall_q <= 1'b1;
							state_q <= ST_INIT;
						end
					end
				end
				ST_INIT: begin
					gap_q     <= count_q;
					swapped_q <= 1'b1;
					state_q   <= ST_PASS;
				end
				ST_PASS: begin
					if (gap_q > CW'(1) || swapped_q) begin
						gap_q     <= CW'(next_gap(7'(gap_q)));
						swapped_q <= 1'b0;
						phase_q   <= 1'b0;
						i_q       <= '0;
						state_q   <= ST_CHK;
					end else begin
						k_q     <= '0;
						state_q <= ST_E_RD;
					end
				end
				ST_CHK: begin
					if (j < SW'(count_q)) begin
						state_q <= ST_RD;
					end else if (!phase_q) begin
						phase_q <= 1'b1;
						i_q     <= SW'(1);
					end else begin
						state_q <= ST_PASS;
					end
				end
				ST_RD: begin
					state_q <= ST_CMP;
				end
				ST_CMP: begin
					if (status.gt) begin
						swapped_q <= 1'b1;
						state_q   <= ST_WR2;
					end else begin
						i_q     <= i_q + SW'(2);
						state_q <= ST_CHK;
					end
				end
				ST_WR2: begin
					i_q     <= i_q + SW'(2);
					state_q <= ST_CHK;
				end
				ST_E_RD: begin
					state_q <= ST_E_LD;
				end
				ST_E_LD: begin
					if (status.out_free) begin
						if (emit_last) begin
							count_q   <= '0;
							gap_q     <= '0;
							swapped_q <= 1'b0;
							dropped_q <= 1'b0;
							stall_q   <= 1'b0;
							state_q   <= ST_LOAD;
						end else begin
							k_q     <= k_q + CW'(1);
							state_q <= ST_E_RD;
						end
					end
				end
				default: begin
					state_q <= ST_LOAD;
					stall_q <= 1'b0;
				end
			endcase
		end
	end

	always_comb begin
		cmd          = '0;
		cmd.wsel     = WSEL_INPUT;
		cmd.out_last = emit_last;
		cmd.out_ovf  = dropped_q;
		waddr        = count_q[AW-1:0];
		raddr_a      = i_q[AW-1:0];
		raddr_b      = j[AW-1:0];
		case (state_q)
			ST_LOAD: begin
				cmd.we = accept && room;
			end
			ST_CMP: begin
				cmd.we      = status.gt;
				cmd.wsel    = WSEL_B;
				cmd.hold_en = 1'b1;
				waddr       = i_q[AW-1:0];
			end
			ST_WR2: begin
				cmd.we   = 1'b1;
				cmd.wsel = WSEL_HOLD;
				waddr    = j[AW-1:0];
			end
			ST_E_RD: begin
				raddr_a = k_q[AW-1:0];
			end
			ST_E_LD: begin
				raddr_a      = k_q[AW-1:0];
				cmd.load_out = status.out_free;
			end
			default: begin
				cmd.we = 1'b0;
			end
		endcase
	end

	assign load_stall = stall_q;

endmodule

/* src/cse_checker.sv */
// Port-level checks for the comb sort engine, bound to the top level.
`include "comb_sort_engine_defines.svh"

module cse_checker import cse_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	input logic      load_valid,
	input logic      load_stall,
	input load_req_t load_data,
	input logic      result_valid,
	input logic      result_stall,
	input result_t   result_data
);

	`CSE_ASSERT_NEXT(a_result_hold, clk, arst_n, result_valid && result_stall, result_valid && $stable(result_data))
	`CSE_ASSERT_NEXT(a_last_stalls, clk, arst_n, load_valid && !load_stall && load_data.last, load_stall)
	`CSE_ASSERT_NEXT(a_load_open, clk, arst_n, load_valid && !load_stall && !load_data.last, !load_stall)
	`CSE_ASSERT_SAME(a_stall_cause, clk, arst_n, $rose(load_stall), $past(load_valid && load_data.last))

endmodule

bind comb_sort_engine cse_checker u_cse_checker (.*);

/* tb/comb_sort_engine_tb.sv */
// Self-checking testbench for the comb sort engine: random batches, idle gaps, sorted-order check.
module comb_sort_engine_tb;
	import cse_pkg::*;

	localparam int DEPTH      = 64;
	localparam int LOAD_ITEMS = 270;
	localparam int DRAIN_MAX  = 200000;

	// Golden sorter: collects the requests of a batch, sorts them on the request
	// marked last and keeps the results the engine must emit, oldest first.
	class sort_scoreboard #(int CAP = 64);
		logic signed [31:0] pool [CAP];
		int                 fill;
		bit                 dropped;
		result_t            sorted_q [$];
		int                 mismatches;
		int                 results_seen;

		function new();
			fill = 0;
			dropped = 0;
			mismatches = 0;
			results_seen = 0;
		endfunction

		// Comb sort with gap shrink 10/13, 9 and 10 raised to 11, and even/odd phases.
		function void comb_sort();
			int                 gap;
			bit                 swapped;
			logic signed [31:0] tmp;
			gap = fill;
			swapped = 1;
			while (gap > 1 || swapped) begin
				gap = gap * 10 / 13;
				if (gap == 9 || gap == 10) begin
					gap = 11;
				end
				if (gap < 1) begin
					gap = 1;
				end
				swapped = 0;
				for (int ph = 0; ph < 2; ph++) begin
					for (int i = ph; i + gap < fill; i += 2) begin
						if (pool[i] > pool[i + gap]) begin
							tmp = pool[i];
							pool[i] = pool[i + gap];
							pool[i + gap] = tmp;
							swapped = 1;
						end
					end
				end
			end
		endfunction

		function void note_load(load_req_t req);
			result_t r;
			if (fill < CAP) begin
				pool[fill] = req.value;
				fill++;
			end else begin
				dropped = 1;
			end
			if (req.last) begin
				comb_sort();
				for (int k = 0; k < fill; k++) begin
					r.sorted_value = pool[k];
					r.last_out     = (k == fill - 1);
					r.overflow     = dropped;
					sorted_q = {sorted_q, r};
				end
				fill = 0;
				dropped = 0;
			end
		endfunction

		task report(string msg);
			mismatches++;
			if (mismatches <= 100) begin
				$display("ERROR: %s", msg);
			end
		endtask

		task check_result(result_t got);
			result_t want;
			results_seen++;
			if (sorted_q.size() == 0) begin
				report($sformatf("result %0d: value %0d arrived with nothing expected",
					results_seen, got.sorted_value));
				return;
			end
			want = sorted_q.pop_front();
			if (got.sorted_value !== want.sorted_value) begin
				report($sformatf("result %0d: sorted_value %0d, want %0d",
					results_seen, got.sorted_value, want.sorted_value));
			end
			if (got.last_out !== want.last_out) begin
				report($sformatf("result %0d: last_out %b, want %b",
					results_seen, got.last_out, want.last_out));
			end
			if (got.overflow !== want.overflow) begin
				report($sformatf("result %0d: overflow %b, want %b",
					results_seen, got.overflow, want.overflow));
			end
		endtask
	endclass

	logic      clk          = 1'b0;
	logic      arst_n       = 1'b0;
	logic      load_valid   = 1'b0;
	logic      load_stall;
	load_req_t load_data    = '0;
	logic      result_valid;
	logic      result_stall = 1'b0;
	result_t   result_data;

	sort_scoreboard #(DEPTH) sb;

	// Zero idling on both sides while set: gives back-to-back stretches.
	bit calm      = 0;
	int loads_sent = 0;

	comb_sort_engine #(.DEPTH(DEPTH)) DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.load_valid   (load_valid),
		.load_stall   (load_stall),
		.load_data    (load_data),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result_data  (result_data)
	);

	initial begin
		forever begin
			#4 clk = ~clk;
		end
	end

	// Idle length: mostly none or short, now and then long.
	function automatic int pick_idle();
		int r;
		if (calm) begin
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 55) begin
			return 0;
		end
		if (r < 92) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(8, 30);
	endfunction

	// Values lean on the sign extremes and a narrow band around zero so that
	// duplicates and sign-boundary compares show up often.
	function automatic logic signed [31:0] pick_value();
		int r;
		r = $urandom_range(0, 9);
		case (r)
			0: begin
				return 32'sh8000_0000;
			end
			1: begin
				return 32'sh7FFF_FFFF;
			end
			2, 3, 4: begin
				return $signed($urandom_range(0, 8)) - 4;
			end
			default: begin
				return $signed($urandom);
			end
		endcase
	endfunction

	// Hold one request until the engine takes it; leave valid high afterwards
	// so a back-to-back request does not toggle it in the same step.
	task send_load(input load_req_t req);
		int idle;
		idle = pick_idle();
		if (idle > 0) begin
			load_valid <= 1'b0;
			repeat (idle) @(posedge clk);
		end
		load_valid <= 1'b1;
		load_data  <= req;
		do begin
			@(posedge clk);
		end while (load_stall);
		sb.note_load(req);
		loads_sent++;
	endtask

	task load_batch(input logic signed [31:0] vals [$]);
		load_req_t req;
		for (int k = 0; k < vals.size(); k++) begin
			req.value = vals[k];
			req.last  = (k == vals.size() - 1);
			send_load(req);
		end
	endtask

	// Result side: check every accepted result, stall in random bursts.
	task run_result_side();
		int hold_left;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (arst_n && result_valid && !result_stall) begin
				sb.check_result(result_data);
			end
			if (hold_left > 0) begin
				result_stall <= 1'b1;
				hold_left--;
			end else begin
				result_stall <= 1'b0;
				hold_left = pick_idle();
			end
		end
	endtask

	initial begin
		run_result_side();
	end

	// Stop a hung run.
	initial begin
		#4000000;
		$display("Mismatches found");
		$finish;
	end

	initial begin
		logic signed [31:0] vals [$];
		int                 batch_idx;
		int                 size;
		int                 waited;
		bit                 big_done;

		sb = new();
		batch_idx = 0;
		big_done = 0;

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: single element, the two extremes reversed, sign boundary
		// with duplicates, all equal, already in order.
		vals = '{32'sh7FFF_FFFF};
		load_batch(vals);
		vals = '{32'sh7FFF_FFFF, 32'sh8000_0000};
		load_batch(vals);
		vals = '{0, -1, 1, 32'sh8000_0000, 32'sh7FFF_FFFF, 0, -1};
		load_batch(vals);
		vals = '{5, 5, 5};
		load_batch(vals);
		vals = '{-3, -2, -1, 0, 1, 2, 3};
		load_batch(vals);

		// Random batches: mostly small, one that fills the store exactly, one
		// whose last request arrives on a full store, maybe one further overfill.
		while (loads_sent < LOAD_ITEMS) begin
			calm = ($urandom_range(0, 4) == 0);
			if (batch_idx == 1) begin
				size = DEPTH;
			end else if (batch_idx == 4) begin
				size = DEPTH + 1;
			end else if (!big_done && $urandom_range(0, 99) < 4) begin
				size = $urandom_range(DEPTH + 2, DEPTH + 6);
				big_done = 1;
			end else begin
				size = $urandom_range(1, 12);
			end
			vals.delete();
			repeat (size) vals = {vals, pick_value()};
			load_batch(vals);
			batch_idx++;
		end
		calm = 0;
		load_valid <= 1'b0;

		// Drain the outstanding results, then give the engine a few more cycles.
		waited = 0;
		while (sb.sorted_q.size() != 0 && waited < DRAIN_MAX) begin
			@(posedge clk);
			waited++;
		end
		repeat (50) @(posedge clk);
		if (sb.sorted_q.size() != 0) begin
			sb.report($sformatf("%0d results never arrived", sb.sorted_q.size()));
		end

		if (sb.mismatches == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule

/* filelist.f */
+incdir+src
src/cse_pkg.sv
src/cse_ram.sv
src/cse_dp.sv
src/cse_ctrl.sv
src/comb_sort_engine.sv
src/cse_checker.sv
tb/comb_sort_engine_tb.sv
